[design/b64wd_pkg.sv]
`default_nettype none
package b64wd_pkg;

	localparam int COUNT_BITS = 16;
	localparam int OUT_COUNT_BITS = 16;
	localparam int SAT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [5:0] SEXTET_PLUS = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2,
		PH_FOURTH = 2'd3
	} phase_t;

	typedef struct packed {
		logic       term;
		logic [5:0] sextet;
	} sym_class_t;

	typedef struct packed {
		logic [7:0]                data;
		logic                      is_end;
		logic [OUT_COUNT_BITS-1:0] byte_count;
	} result_t;

	function automatic sym_class_t classify(input logic [7:0] c);
		sym_class_t r;
		r.term = 1'b0;
		r.sextet = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r.sextet = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c inside {8'h2B, 8'h2D}) begin
			r.sextet = SEXTET_PLUS;
		end else if (c inside {8'h2F, 8'h2E}) begin
			r.sextet = SEXTET_SLASH;
		end else begin
			r.term = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[design/b64wd_front.sv]
`default_nettype none
module b64wd_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [7:0]             symbol,
	output logic                        full,
	output logic                        cls_valid,
	output b64wd_pkg::sym_class_t       cls,
	input  wire logic                   cls_take
);

	b64wd_pkg::sym_class_t              entry_q [b64wd_pkg::QUEUE_DEPTH];
	logic [b64wd_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [b64wd_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [b64wd_pkg::QCNT_BITS-1:0]    cnt_q;
	logic                               wr;
	logic                               rd;

	assign full = (cnt_q == b64wd_pkg::QCNT_BITS'(b64wd_pkg::QUEUE_DEPTH));
	assign cls_valid = (cnt_q != '0);
	assign cls = entry_q[rd_ptr_q];
	assign wr = push && !full;
	assign rd = cls_take && cls_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == b64wd_pkg::QPTR_BITS'(b64wd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == b64wd_pkg::QPTR_BITS'(b64wd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= b64wd_pkg::classify(symbol);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= b64wd_pkg::QCNT_BITS'(b64wd_pkg::QUEUE_DEPTH))
		else $error("front queue count out of range");
	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |=> !($past(rd)))
		else $error("front queue read while empty");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("front queue count lost an item");
`endif

endmodule
`default_nettype wire

[design/b64wd_back.sv]
`default_nettype none
module b64wd_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cls_valid,
	input  wire b64wd_pkg::sym_class_t                cls,
	output logic                                      cls_take,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic [7:0]                                data,
	output logic                                      is_end,
	output logic [b64wd_pkg::OUT_COUNT_BITS-1:0]      byte_count
);

	b64wd_pkg::phase_t                      phase_q;
	logic [5:0]                             held_q;
	logic [b64wd_pkg::COUNT_BITS-1:0]       total_q;

	b64wd_pkg::result_t                     res_q [b64wd_pkg::QUEUE_DEPTH];
	logic [b64wd_pkg::QPTR_BITS-1:0]        wr_ptr_q;
	logic [b64wd_pkg::QPTR_BITS-1:0]        rd_ptr_q;
	logic [b64wd_pkg::QCNT_BITS-1:0]        cnt_q;

	logic                                   res_full;
	logic                                   produces;
	logic                                   wr;
	logic                                   rd;
	logic [7:0]                             byte_val;
	logic [b64wd_pkg::SAT_BITS-1:0]         total_wide;
	b64wd_pkg::result_t                     res_new;
	b64wd_pkg::result_t                     res_head;

	assign res_full = (cnt_q == b64wd_pkg::QCNT_BITS'(b64wd_pkg::QUEUE_DEPTH));
	assign cls_take = cls_valid && !res_full;
	assign produces = cls.term || (phase_q != b64wd_pkg::PH_FIRST);
	assign wr = cls_take && produces;
	assign rd = pop && !empty;
	assign empty = (cnt_q == '0);
	assign total_wide = b64wd_pkg::SAT_BITS'(total_q);

	assign res_head = res_q[rd_ptr_q];
	assign data = res_head.data;
	assign is_end = res_head.is_end;
	assign byte_count = res_head.byte_count;

	always_comb begin
		case (phase_q)
			b64wd_pkg::PH_SECOND: byte_val = {held_q, cls.sextet[5:4]};
			b64wd_pkg::PH_THIRD:  byte_val = {held_q[3:0], cls.sextet[5:2]};
			b64wd_pkg::PH_FOURTH: byte_val = {held_q[1:0], cls.sextet};
			default:              byte_val = 8'd0;
		endcase
	end

	always_comb begin
		res_new.data = 8'd0;
		res_new.is_end = 1'b0;
		res_new.byte_count = '0;
		if (cls.term) begin
			res_new.is_end = 1'b1;
			if (total_wide > b64wd_pkg::SAT_BITS'({b64wd_pkg::OUT_COUNT_BITS{1'b1}})) begin
				res_new.byte_count = '1;
			end else begin
				res_new.byte_count = total_wide[b64wd_pkg::OUT_COUNT_BITS-1:0];
			end
		end else begin
			res_new.data = byte_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64wd_pkg::PH_FIRST;
			held_q <= '0;
			total_q <= '0;
		end else if (cls_take) begin
			if (cls.term) begin
				phase_q <= b64wd_pkg::PH_FIRST;
				held_q <= '0;
				total_q <= '0;
			end else begin
				phase_q <= b64wd_pkg::phase_t'(phase_q + 2'd1);
				held_q <= cls.sextet;
				if (phase_q != b64wd_pkg::PH_FIRST && total_q != '1) begin
					total_q <= total_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == b64wd_pkg::QPTR_BITS'(b64wd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == b64wd_pkg::QPTR_BITS'(b64wd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			res_q[wr_ptr_q] <= res_new;
		end
	end

`ifndef SYNTHESIS
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= b64wd_pkg::QCNT_BITS'(b64wd_pkg::QUEUE_DEPTH))
		else $error("result queue count out of range");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_take && cls.term) |=> (phase_q == b64wd_pkg::PH_FIRST && total_q == '0))
		else $error("group state not cleared after terminator");
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_take && !cls.term) |=> (total_q >= $past(total_q)))
		else $error("byte total decreased within a message");
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_take && !cls.term && phase_q == b64wd_pkg::PH_FIRST) |-> !wr)
		else $error("first character of a group produced an item");
`endif

endmodule
`default_nettype wire

[design/base64_web_variant_decoder.sv]
// Channel   Handshake          Payload
// input     push / full        symbol[7:0]
// result    empty / pop        data[7:0], is_end, byte_count[15:0]
//
// One character is taken per cycle while full is low. Any result that it yields is
// registered in the result queue and stays on the result ports until it is popped.
// The sextet lookup sits in front of a two-entry queue and the group splice and
// byte counter sit behind it, followed by a two-entry result queue.
// A full result queue stalls the back end, and the front queue then fills and raises full.
// Reset clears both queues, the group phase, the held sextet and the byte count.
`default_nettype none
module base64_web_variant_decoder (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic [7:0]                           symbol,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic [7:0]                                data,
	output logic                                      is_end,
	output logic [b64wd_pkg::OUT_COUNT_BITS-1:0]      byte_count
);

	logic                   cls_valid;
	logic                   cls_take;
	b64wd_pkg::sym_class_t  cls;

	b64wd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.symbol    (symbol),
		.full      (full),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_take  (cls_take)
	);

	b64wd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls_valid  (cls_valid),
		.cls        (cls),
		.cls_take   (cls_take),
		.empty      (empty),
		.pop        (pop),
		.data       (data),
		.is_end     (is_end),
		.byte_count (byte_count)
	);

endmodule
`default_nettype wire

[tb/b64wd_tb_pkg.sv]
package b64wd_tb_pkg;
	import b64wd_pkg::*;

	class decode_scoreboard;
		phase_t          phase;
		logic [5:0]      held;
		longint unsigned total;
		result_t         pending_results[$];
		int unsigned     failures;
		int unsigned     reported;

		function new();
			phase = PH_FIRST;
			held = '0;
			total = 0;
			failures = 0;
			reported = 0;
		endfunction

		function bit lookup_sextet(input logic [7:0] c, output logic [5:0] s);
			bit found;
			found = 1'b1;
			s = '0;
			if (c >= "A" && c <= "Z") begin
				s = 6'(c - "A");
			end else if (c >= "a" && c <= "z") begin
				s = 6'(c - "a" + 26);
			end else if (c >= "0" && c <= "9") begin
				s = 6'(c - "0" + 52);
			end else if (c == "+" || c == "-") begin
				s = 6'd62;
			end else if (c == "/" || c == ".") begin
				s = 6'd63;
			end else begin
				found = 1'b0;
			end
			return found;
		endfunction

		function void note_symbol(input logic [7:0] c);
			logic [5:0]      s;
			result_t         r;
			longint unsigned count_cap;
			longint unsigned out_cap;
			count_cap = (64'd1 << COUNT_BITS) - 1;
			out_cap = (64'd1 << OUT_COUNT_BITS) - 1;
			if (!lookup_sextet(c, s)) begin
				r.data = '0;
				r.is_end = 1'b1;
				r.byte_count = OUT_COUNT_BITS'((total > out_cap) ? out_cap : total);
				pending_results.push_back(r);
				phase = PH_FIRST;
				held = '0;
				total = 0;
			end else begin
				r.is_end = 1'b0;
				r.byte_count = '0;
				case (phase)
					PH_SECOND: r.data = {held, s[5:4]};
					PH_THIRD:  r.data = {held[3:0], s[5:2]};
					PH_FOURTH: r.data = {held[1:0], s};
					default:   r.data = '0;
				endcase
				if (phase != PH_FIRST) begin
					if (total < count_cap) begin
						total++;
					end
					pending_results.push_back(r);
				end
				phase = (phase == PH_FOURTH) ? PH_FIRST : phase_t'(phase + 2'd1);
				held = s;
			end
		endfunction

		function void check_result(input logic [7:0] d, input logic e,
				input logic [OUT_COUNT_BITS-1:0] n);
			result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("%0t: unexpected result data=%h is_end=%b byte_count=%0d",
						$time, d, e, n);
				end
			end else begin
				want = pending_results.pop_front();
				if (d !== want.data || e !== want.is_end || n !== want.byte_count) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("%0t: expected data=%h is_end=%b byte_count=%0d, got data=%h is_end=%b byte_count=%0d",
							$time, want.data, want.is_end, want.byte_count, d, e, n);
					end
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		function void close_out();
			if (pending_results.size() != 0) begin
				failures += pending_results.size();
				$display("%0d results never arrived", pending_results.size());
			end
		endfunction
	endclass

endpackage

[tb/tb_base64_web_variant_decoder.sv]
module tb_base64_web_variant_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import b64wd_pkg::*;
	import b64wd_tb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1650;
	localparam logic [7:0] OPENING [25] = '{
		8'h3D, "A", "Z", "a", "z", "0", "9", "+", "-", "/", ".", 8'h3D, "Q", 8'h5F,
		8'h00, "/", "/", ".", ".", 8'hFF, "9", 8'h80, 8'h2C, 8'h40, 8'h7B
	};

	logic                      clk;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	logic [7:0]                symbol;
	logic                      empty;
	logic                      pop;
	logic [7:0]                data;
	logic                      is_end;
	logic [OUT_COUNT_BITS-1:0] byte_count;

	decode_scoreboard board;
	bit                out_of_reset;
	bit                send_idle;
	bit                pop_idle;
	bit                progressed;
	int unsigned       quiet_cycles;
	int unsigned       sent_items;

	base64_web_variant_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.symbol     (symbol),
		.empty      (empty),
		.pop        (pop),
		.data       (data),
		.is_end     (is_end),
		.byte_count (byte_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_symbol(input logic [7:0] c);
		int gap;
		bit taken;
		gap = send_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push = 1'b1;
		symbol = c;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (!full) begin
				taken = 1'b1;
				board.note_symbol(c);
				progressed = 1'b1;
				sent_items++;
			end
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		push = 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] alphabet_char(input logic [5:0] s, input bit alt);
		logic [7:0] c;
		if (s < 26) begin
			c = 8'("A" + s);
		end else if (s < 52) begin
			c = 8'("a" + s - 26);
		end else if (s < 62) begin
			c = 8'("0" + s - 52);
		end else if (s == 62) begin
			c = alt ? "-" : "+";
		end else begin
			c = alt ? "." : "/";
		end
		return c;
	endfunction

	function automatic logic [7:0] random_terminator();
		logic [7:0] c;
		logic [5:0] s;
		case ($urandom_range(0, 7))
			0: c = 8'h3D;
			1: c = 8'h5F;
			2: c = 8'h00;
			default: begin
				c = 8'($urandom_range(0, 255));
				while (board.lookup_sextet(c, s)) c = 8'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	initial begin
		pop = 1'b0;
		wait (out_of_reset);
		forever begin
			int  gap;
			bit  taken;
			gap = pop_idle ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				@(negedge clk);
				pop = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			pop = 1'b1;
			taken = 1'b0;
			while (!taken) begin
				@(posedge clk);
				if (!empty) begin
					taken = 1'b1;
					board.check_result(data, is_end, byte_count);
					progressed = 1'b1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (progressed) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		progressed = 1'b0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int unsigned random_start;
		int          len;
		board = new();
		arst_n = 1'b0;
		push = 1'b0;
		symbol = '0;
		send_idle = 1'b1;
		pop_idle = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		out_of_reset = 1'b1;

		foreach (OPENING[i]) send_symbol(OPENING[i]);
		wait_for_results();

		random_start = sent_items;
		while (sent_items - random_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin send_idle = 1'b0; pop_idle = 1'b0; end
				1: begin send_idle = 1'b0; pop_idle = 1'b1; end
				2: begin send_idle = 1'b1; pop_idle = 1'b0; end
				default: begin send_idle = 1'b1; pop_idle = 1'b1; end
			endcase
			if ($urandom_range(0, 39) == 0) wait_for_results();
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 8);
				repeat (len) send_symbol(8'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(0, 20);
				repeat (len) begin
					send_symbol(alphabet_char(6'($urandom_range(0, 63)),
						1'($urandom_range(0, 1))));
				end
				send_symbol(random_terminator());
			end
		end

		wait_for_results();
		repeat (20) @(posedge clk);
		board.close_out();
		if (board.failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
design/b64wd_pkg.sv
design/b64wd_front.sv
design/b64wd_back.sv
design/base64_web_variant_decoder.sv
tb/b64wd_tb_pkg.sv
tb/tb_base64_web_variant_decoder.sv
